// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== src/s2s_pkg.sv =====
// Types, constants and segment table for the seven-segment digit writer
package s2s_pkg;
	localparam int VALUE_W = 32;
	localparam int MAG_W   = 27;
	localparam int POS_W   = 4;
	localparam int SEG_W   = 8;
	localparam int DIG_W   = 4;

	localparam logic signed [VALUE_W-1:0] LOW_LIMIT  = 32'sd10000000;
	localparam logic signed [VALUE_W-1:0] HIGH_LIMIT = 32'sd100000000;
	localparam logic [31:0]      RECIP_10   = 32'hCCCC_CCCD;
	localparam int               RECIP_SH   = 35;
	localparam logic [SEG_W-1:0] SEG_MINUS  = 8'h40;
	localparam logic [7:0]       GRID_TOP   = 8'hD0;
	localparam logic [POS_W-1:0] POS_FIRST  = 4'd1;
	localparam logic [POS_W-1:0] POS_MAX    = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	function automatic logic [SEG_W-1:0] digit_seg(input logic [DIG_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0:    s = 8'h3F;
			4'd1:    s = 8'h06;
			4'd2:    s = 8'h5B;
			4'd3:    s = 8'h4F;
			4'd4:    s = 8'h66;
			4'd5:    s = 8'h6D;
			4'd6:    s = 8'h7D;
			4'd7:    s = 8'h27;
			4'd8:    s = 8'h7F;
			4'd9:    s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction
endpackage

// ===== src/signed_int_to_seven_segment.sv =====
// Top level: signed integer to eight-digit seven-segment write sequence
// Accepting a value enters ST_EMIT, which loads each word once the output slot is free.
// Throughput: one word per cycle unless m_tready stalls, via a single divide-by-ten unit;
// one step per digit; s_tready stays low until all of a value's 1 to 8 words are loaded.
// Reset: arst_n clears the sequencer and output valid asynchronously; no other state.
`include "assert_macros.svh"
module signed_int_to_seven_segment
	import s2s_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value[31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // position[3:0], segments[11:4], grid_address[19:12], zero[23:20]
	output logic        m_tlast   // last
);
	state_t            state_q;
	logic [MAG_W-1:0]  mag_q;
	logic [POS_W-1:0]  pos_q;
	logic              neg_q;
	logic              ovf_q;
	logic              zero_q;
	logic              m_tvalid_q;
	logic              m_tlast_q;
	logic [23:0]       m_tdata_q;

	logic                      accept;
	logic                      load;
	logic signed [VALUE_W-1:0] value;
	logic [VALUE_W-1:0]        abs_v;
	logic [MAG_W-1:0]          quo;
	logic [DIG_W-1:0]          rem;
	logic [SEG_W-1:0]          seg_w;
	logic                      last_w;
	logic                      digit_w;
	logic [7:0]                grid_w;

	s2s_div10 u_div10 (
		.x (mag_q),
		.q (quo),
		.r (rem)
	);

	assign value  = $signed(s_tdata);
	assign abs_v  = value[VALUE_W-1] ? VALUE_W'(-value) : s_tdata;
	assign accept = s_tvalid && s_tready;
	assign load   = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
	assign grid_w = GRID_TOP - {3'b000, pos_q, 1'b0};

	always_comb begin
		digit_w = 1'b0;
		if (ovf_q) begin
			seg_w  = SEG_MINUS;
			last_w = (pos_q == POS_MAX);
		end else if (zero_q) begin
			seg_w  = digit_seg('0);
			last_w = 1'b1;
		end else if (mag_q != '0) begin
			seg_w   = digit_seg(rem);
			last_w  = (quo == '0) && !neg_q;
			digit_w = 1'b1;
		end else begin
			seg_w  = SEG_MINUS;
			last_w = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load && last_w) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q  <= abs_v[MAG_W-1:0];
			pos_q  <= POS_FIRST;
			neg_q  <= value[VALUE_W-1];
			zero_q <= (s_tdata == '0);
			ovf_q  <= (value <= -LOW_LIMIT) || (value >= HIGH_LIMIT);
		end else if (load) begin
			pos_q <= pos_q + POS_FIRST;
			if (digit_w) mag_q <= quo;
		end
		if (load) begin
			m_tdata_q <= {4'b0000, grid_w, seg_w, pos_q};
			m_tlast_q <= last_w;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	`ASSERT_IMPL(a_pos_range, clk, arst_n, m_tvalid, (m_tdata[3:0] != 4'd0) && (m_tdata[3:0] <= POS_MAX))
	`ASSERT_IMPL(a_grid_match, clk, arst_n, m_tvalid, m_tdata[19:12] == (GRID_TOP - {3'b000, m_tdata[3:0], 1'b0}))
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !s_tready)
	`ASSERT_IMPL(a_load_slot_free, clk, arst_n, load, !m_tvalid_q || m_tready)
endmodule

// ===== src/s2s_div10.sv =====
// Divide-by-ten step: quotient by reciprocal multiply, remainder as the digit
module s2s_div10
	import s2s_pkg::*;
(
	input  logic [MAG_W-1:0] x,
	output logic [MAG_W-1:0] q,
	output logic [DIG_W-1:0] r
);
	logic [MAG_W+31:0] prod;
	logic [MAG_W-1:0]  q10;
	logic [MAG_W-1:0]  diff;

	assign prod = {32'd0, x} * {{MAG_W{1'b0}}, RECIP_10};
	assign q    = MAG_W'(prod >> RECIP_SH);
	assign q10  = MAG_W'({q, 3'b000}) + MAG_W'({q, 1'b0});
	assign diff = x - q10;
	assign r    = diff[DIG_W-1:0];
endmodule
